### rtl/ppmrc_pkg.sv
// ppmrc_pkg: shared types and request codes for the ppm rc channel decoder
// used by every module in rtl/, depends on nothing else
package ppmrc_pkg;

    localparam int REQ_W   = 3;
    localparam int TIME_W  = 16;
    localparam int CH_W    = 8;
    localparam int PULSE_W = 16;
    localparam int OVR_W   = 15;
    localparam int MINCH_W = 4;
    localparam int SEEN_W  = 4;
    localparam int CFG_A_W = 3;

    localparam logic [REQ_W-1:0] REQ_CAPTURE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET_OVR   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TAKE_FLAG = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLR_OVR   = 3'd4;

    localparam logic [CFG_A_W-1:0] CFG_TIMER_TOP    = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_SYNC_THRESH  = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_MIN_CHANNELS = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_MIN_PULSE    = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_MAX_PULSE    = 3'd4;

    localparam logic [TIME_W-1:0]  TIMER_TOP_RST    = 16'd40000;
    localparam logic [TIME_W-1:0]  SYNC_THRESH_RST  = 16'd4600;
    localparam logic [MINCH_W-1:0] MIN_CHANNELS_RST = 4'd5;
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST    = 16'd900;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST    = 16'd2100;

    typedef struct packed {
        logic [TIME_W-1:0]  timer_top;
        logic [TIME_W-1:0]  sync_threshold;
        logic [MINCH_W-1:0] min_channels;
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
    } cfg_t;

    typedef struct packed {
        logic              sync_seen;
        logic              publish;
        logic              store_gap;
        logic [TIME_W-1:0] gap;
    } edge_ctl_t;

endpackage

### rtl/ppmrc_frame_ctl.sv
// ppmrc_frame_ctl: edge gap with timer wrap, sync detect and frame slot control
// depends on ppmrc_pkg
module ppmrc_frame_ctl #(
    parameter int CHAN_COUNT = 8
) (
    input  logic [ppmrc_pkg::TIME_W-1:0]           capture_time,
    input  logic [ppmrc_pkg::TIME_W-1:0]           last_edge_time,
    input  logic [$clog2(CHAN_COUNT+1)-1:0]        frame_slot,
    input  ppmrc_pkg::cfg_t                        cfg,
    output ppmrc_pkg::edge_ctl_t                   ctl,
    output logic [$clog2(CHAN_COUNT+1)-1:0]        slot_next,
    output logic [$clog2(CHAN_COUNT+1)-1:0]        pub_count
);

    localparam int CNT_W = $clog2(CHAN_COUNT + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(CHAN_COUNT);

    logic [ppmrc_pkg::TIME_W-1:0] wrap_add;
    logic [ppmrc_pkg::TIME_W-1:0] gap;
    logic                         sync_seen;
    logic                         enough;
    logic                         store_gap;
    logic                         now_full;

    // gap is taken modulo 2^16, adding the wrap value when the timer rolled over
    assign wrap_add  = (capture_time < last_edge_time) ? cfg.timer_top : '0;
    assign gap       = capture_time - last_edge_time + wrap_add;
    assign sync_seen = gap > cfg.sync_threshold;
    assign enough    = 5'(frame_slot) >= 5'(cfg.min_channels);
    assign store_gap = !sync_seen && (frame_slot < FULL);
    assign now_full  = store_gap && ((frame_slot + CNT_W'(1)) == FULL);

    assign ctl.sync_seen = sync_seen;
    assign ctl.publish   = (sync_seen && enough) || now_full;
    assign ctl.store_gap = store_gap;
    assign ctl.gap       = gap;

    assign slot_next = sync_seen ? '0 : (store_gap ? frame_slot + CNT_W'(1) : frame_slot);
    assign pub_count = sync_seen ? frame_slot : FULL;

endmodule

### rtl/ppmrc_read_path.sv
// ppmrc_read_path: halves a stored width, clamps it, applies an override
// depends on ppmrc_pkg
module ppmrc_read_path (
    input  logic [ppmrc_pkg::TIME_W-1:0]  width,
    input  logic [ppmrc_pkg::OVR_W-1:0]   override_val,
    input  logic                          ch_in_range,
    input  ppmrc_pkg::cfg_t               cfg,
    output logic [ppmrc_pkg::PULSE_W-1:0] pulse
);

    logic [ppmrc_pkg::PULSE_W-1:0] half;
    logic [ppmrc_pkg::PULSE_W-1:0] clamped;

    assign half = {1'b0, width[ppmrc_pkg::TIME_W-1:1]};

    // if the limits cross, a half above max_pulse gets it, else min_pulse
    always_comb begin
        priority if (half > cfg.max_pulse) begin
            clamped = cfg.max_pulse;
        end else if (half < cfg.min_pulse) begin
            clamped = cfg.min_pulse;
        end else begin
            clamped = half;
        end
    end

    always_comb begin
        priority if (!ch_in_range) begin
            pulse = '0;
        end else if (override_val != '0) begin
            pulse = {1'b0, override_val};
        end else begin
            pulse = clamped;
        end
    end

endmodule

### rtl/ppm_rc_channel_decoder_top.sv
// ppm_rc_channel_decoder_top: ppm rc frame decoder with input and result registers
// depends on ppmrc_pkg, ppmrc_frame_ctl and ppmrc_read_path
//
// One item in, one result item out. An item is taken into an input register,
// handled there by a short subtract / compare / select path that
// updates the decoder state, and its result lands in an output register.
// Throughput is one item per clock while m_ready keeps the result register
// free; m_valid rises when an item moves from the input register into the
// result register. s_ready is high while the input register is empty or
// moves on into the result register in the same cycle; with both registers
// full and m_ready low it drops, so a stalled receiver holds two items.
// Capture items (req_type 0) take the gap to the previous edge; a gap above
// sync_threshold closes the frame, one at or below it fills the next free slot.
// Read items return the stored width halved to microseconds and clamped to
// [min_pulse, max_pulse], or the override when one is set. Configuration writes
// use cfg_wr_en / cfg_addr / cfg_wdata and are meant for idle periods only.
module ppm_rc_channel_decoder_top #(
    parameter int CHAN_COUNT = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [ppmrc_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [15:0]                       cfg_wdata,
    // input item channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ppmrc_pkg::REQ_W-1:0]       s_req_type,
    input  logic [ppmrc_pkg::TIME_W-1:0]      s_capture_time,
    input  logic [ppmrc_pkg::CH_W-1:0]        s_channel_index,
    input  logic signed [15:0]                s_override_value,
    // result item channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ppmrc_pkg::PULSE_W-1:0]     m_pulse_value,
    output logic                              m_override_taken,
    output logic                              m_new_flag,
    output logic [ppmrc_pkg::SEEN_W-1:0]      m_channels_seen
);

    localparam int CNT_W = $clog2(CHAN_COUNT + 1);
    localparam int IDX_W = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;

    // configuration registers
    ppmrc_pkg::cfg_t cfg_reg;

    // input register
    logic                            in_valid_reg;
    logic [ppmrc_pkg::REQ_W-1:0]     req_reg;
    logic [ppmrc_pkg::TIME_W-1:0]    cap_reg;
    logic [ppmrc_pkg::CH_W-1:0]      ch_reg;
    logic [15:0]                     ov_reg;

    // decoder state
    logic [ppmrc_pkg::TIME_W-1:0]    last_edge_reg;
    logic [CNT_W-1:0]                frame_slot_reg;
    logic [CNT_W-1:0]                published_reg;
    logic                            fresh_reg;
    logic [ppmrc_pkg::TIME_W-1:0]    width_store_reg [CHAN_COUNT];
    logic [ppmrc_pkg::OVR_W-1:0]     override_store_reg [CHAN_COUNT];

    // result register
    logic                            out_valid_reg;
    logic [ppmrc_pkg::PULSE_W-1:0]   pulse_reg;
    logic                            taken_reg;
    logic                            flag_reg;
    logic [ppmrc_pkg::SEEN_W-1:0]    seen_reg;

    logic                            advance;
    logic                            fire;
    logic                            s_take;
    logic                            is_capture;
    logic                            is_read;
    logic                            is_set_ovr;
    logic                            is_take;
    logic                            is_clr_ovr;
    logic                            ch_in_range;
    logic [IDX_W-1:0]                ch_idx;
    logic [IDX_W-1:0]                slot_idx;
    logic                            ovr_write;
    ppmrc_pkg::edge_ctl_t            edge_ctl;
    logic [CNT_W-1:0]                slot_next;
    logic [CNT_W-1:0]                pub_count;
    logic [CNT_W-1:0]                published_next;
    logic                            fresh_next;
    logic [ppmrc_pkg::PULSE_W-1:0]   read_pulse;

    // handshake: the result register frees when taken, the input register
    // empties into it whenever it is free
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    assign is_capture = (req_reg == ppmrc_pkg::REQ_CAPTURE);
    assign is_read    = (req_reg == ppmrc_pkg::REQ_READ);
    assign is_set_ovr = (req_reg == ppmrc_pkg::REQ_SET_OVR);
    assign is_take    = (req_reg == ppmrc_pkg::REQ_TAKE_FLAG);
    assign is_clr_ovr = (req_reg == ppmrc_pkg::REQ_CLR_OVR);

    assign ch_in_range = ch_reg < ppmrc_pkg::CH_W'(CHAN_COUNT);
    assign ch_idx      = ch_reg[IDX_W-1:0];
    assign slot_idx    = frame_slot_reg[IDX_W-1:0];

    // negative override value leaves the store alone
    assign ovr_write = is_set_ovr && !ov_reg[15] && ch_in_range;

    ppmrc_frame_ctl #(
        .CHAN_COUNT (CHAN_COUNT)
    ) u_frame_ctl (
        .capture_time   (cap_reg),
        .last_edge_time (last_edge_reg),
        .frame_slot     (frame_slot_reg),
        .cfg            (cfg_reg),
        .ctl            (edge_ctl),
        .slot_next      (slot_next),
        .pub_count      (pub_count)
    );

    ppmrc_read_path u_read_path (
        .width        (width_store_reg[ch_idx]),
        .override_val (override_store_reg[ch_idx]),
        .ch_in_range  (ch_in_range),
        .cfg          (cfg_reg),
        .pulse        (read_pulse)
    );

    // flag and published count after this item
    always_comb begin
        published_next = published_reg;
        fresh_next     = fresh_reg;
        if (is_capture && edge_ctl.publish) begin
            published_next = pub_count;
            fresh_next     = 1'b1;
        end
        if (ovr_write && (ov_reg != '0)) begin
            fresh_next = 1'b1;
        end
        if (is_take) begin
            fresh_next = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timer_top      <= ppmrc_pkg::TIMER_TOP_RST;
            cfg_reg.sync_threshold <= ppmrc_pkg::SYNC_THRESH_RST;
            cfg_reg.min_channels   <= ppmrc_pkg::MIN_CHANNELS_RST;
            cfg_reg.min_pulse      <= ppmrc_pkg::MIN_PULSE_RST;
            cfg_reg.max_pulse      <= ppmrc_pkg::MAX_PULSE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                ppmrc_pkg::CFG_TIMER_TOP:    cfg_reg.timer_top      <= cfg_wdata;
                ppmrc_pkg::CFG_SYNC_THRESH:  cfg_reg.sync_threshold <= cfg_wdata;
                ppmrc_pkg::CFG_MIN_CHANNELS: cfg_reg.min_channels   <= cfg_wdata[3:0];
                ppmrc_pkg::CFG_MIN_PULSE:    cfg_reg.min_pulse      <= cfg_wdata;
                ppmrc_pkg::CFG_MAX_PULSE:    cfg_reg.max_pulse      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            req_reg <= s_req_type;
            cap_reg <= s_capture_time;
            ch_reg  <= s_channel_index;
            ov_reg  <= s_override_value;
        end
    end

    // scalar decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_edge_reg  <= '0;
            frame_slot_reg <= '0;
            published_reg  <= '0;
            fresh_reg      <= 1'b0;
        end else if (fire) begin
            published_reg <= published_next;
            fresh_reg     <= fresh_next;
            if (is_capture) begin
                last_edge_reg  <= cap_reg;
                frame_slot_reg <= slot_next;
            end
        end
    end

    // channel width and override stores, one register per channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHAN_COUNT; i++) begin
                width_store_reg[i]    <= '0;
                override_store_reg[i] <= '0;
            end
        end else if (fire) begin
            for (int i = 0; i < CHAN_COUNT; i++) begin
                if (is_capture && edge_ctl.store_gap && (slot_idx == IDX_W'(i))) begin
                    width_store_reg[i] <= edge_ctl.gap;
                end
                if (is_clr_ovr) begin
                    override_store_reg[i] <= '0;
                end else if (ovr_write && (ch_idx == IDX_W'(i))) begin
                    override_store_reg[i] <= ov_reg[14:0];
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            pulse_reg <= is_read ? read_pulse : '0;
            taken_reg <= ovr_write && (ov_reg != '0);
            // a take reports the flag as it stood before clearing
            flag_reg  <= is_take ? fresh_reg : fresh_next;
            seen_reg  <= ppmrc_pkg::SEEN_W'(published_next);
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_pulse_value    = pulse_reg;
    assign m_override_taken = taken_reg;
    assign m_new_flag       = flag_reg;
    assign m_channels_seen  = seen_reg;

endmodule

### sim/ppmrc_reply_checker.sv
// ppmrc_reply_checker: watches both item channels and the register port of the
// ppm rc channel decoder, predicts every reply item and compares it in order
// depends on ppmrc_pkg for field widths, request codes and register indexes
module ppmrc_reply_checker #(
    parameter int CHAN_COUNT = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ppmrc_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [15:0]                       cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [ppmrc_pkg::REQ_W-1:0]       s_req_type,
    input  logic [ppmrc_pkg::TIME_W-1:0]      s_capture_time,
    input  logic [ppmrc_pkg::CH_W-1:0]        s_channel_index,
    input  logic signed [15:0]                s_override_value,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [ppmrc_pkg::PULSE_W-1:0]     m_pulse_value,
    input  logic                              m_override_taken,
    input  logic                              m_new_flag,
    input  logic [ppmrc_pkg::SEEN_W-1:0]      m_channels_seen,
    output int                                mismatch_count,
    output int                                replies_pending
);
    import ppmrc_pkg::*;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_value;
        logic               override_taken;
        logic               new_flag;
        logic [SEEN_W-1:0]  channels_seen;
    } reply_t;

    cfg_t              regs;
    logic [TIME_W-1:0] prev_edge;
    int                slot;
    int                frame_count;
    logic              fresh;
    logic [TIME_W-1:0] widths [CHAN_COUNT];
    logic [OVR_W-1:0]  overrides [CHAN_COUNT];

    reply_t replies_due [$];
    int     faults;
    int     replies_seen;

    // applies one request to the decoder state and returns its reply item
    function automatic reply_t decode_item(input logic [REQ_W-1:0]  req,
                                           input logic [TIME_W-1:0] now,
                                           input logic [CH_W-1:0]   ch,
                                           input logic [15:0]       ovr);
        reply_t             r;
        logic [TIME_W-1:0]  gap;
        logic [PULSE_W-1:0] w;
        logic               flag_before;
        logic               took_flag;
        r = '0;
        flag_before = 1'b0;
        took_flag = 1'b0;
        case (req)
            REQ_CAPTURE: begin
                // 16 bit arithmetic wraps the same way the timer does
                if (now < prev_edge)
                    gap = now + regs.timer_top - prev_edge;
                else
                    gap = now - prev_edge;
                if (gap > regs.sync_threshold) begin
                    if (slot >= regs.min_channels) begin
                        frame_count = slot;
                        fresh = 1'b1;
                    end
                    slot = 0;
                end else if (slot < CHAN_COUNT) begin
                    widths[slot] = gap;
                    slot++;
                    if (slot == CHAN_COUNT) begin
                        frame_count = CHAN_COUNT;
                        fresh = 1'b1;
                    end
                end
                prev_edge = now;
            end
            REQ_READ: begin
                if (ch < CHAN_COUNT) begin
                    w = {1'b0, widths[ch][TIME_W-1:1]};
                    if (w > regs.max_pulse)
                        w = regs.max_pulse;
                    else if (w < regs.min_pulse)
                        w = regs.min_pulse;
                    if (overrides[ch] != '0)
                        w = {1'b0, overrides[ch]};
                    r.pulse_value = w;
                end
            end
            REQ_SET_OVR: begin
                if (!ovr[15] && ch < CHAN_COUNT) begin
                    overrides[ch] = ovr[OVR_W-1:0];
                    if (ovr != '0) begin
                        fresh = 1'b1;
                        r.override_taken = 1'b1;
                    end
                end
            end
            REQ_TAKE_FLAG: begin
                flag_before = fresh;
                fresh = 1'b0;
                took_flag = 1'b1;
            end
            REQ_CLR_OVR: begin
                for (int i = 0; i < CHAN_COUNT; i++)
                    overrides[i] = '0;
            end
            default: begin
            end
        endcase
        r.new_flag = took_flag ? flag_before : fresh;
        r.channels_seen = frame_count[SEEN_W-1:0];
        return r;
    endfunction

    task automatic log_fault(input string msg);
        faults++;
        if (faults <= 10)
            $display("%s", msg);
    endtask

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (!aresetn) begin
            regs.timer_top      = TIMER_TOP_RST;
            regs.sync_threshold = SYNC_THRESH_RST;
            regs.min_channels   = MIN_CHANNELS_RST;
            regs.min_pulse      = MIN_PULSE_RST;
            regs.max_pulse      = MAX_PULSE_RST;
            prev_edge = '0;
            slot = 0;
            frame_count = 0;
            fresh = 1'b0;
            for (int i = 0; i < CHAN_COUNT; i++) begin
                widths[i] = '0;
                overrides[i] = '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_TIMER_TOP:    regs.timer_top = cfg_wdata;
                    CFG_SYNC_THRESH:  regs.sync_threshold = cfg_wdata;
                    CFG_MIN_CHANNELS: regs.min_channels = cfg_wdata[MINCH_W-1:0];
                    CFG_MIN_PULSE:    regs.min_pulse = cfg_wdata;
                    CFG_MAX_PULSE:    regs.max_pulse = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                got.pulse_value    = m_pulse_value;
                got.override_taken = m_override_taken;
                got.new_flag       = m_new_flag;
                got.channels_seen  = m_channels_seen;
                if (replies_due.size() == 0) begin
                    log_fault($sformatf("unexpected item: pulse %0d taken %0b flag %0b seen %0d",
                        got.pulse_value, got.override_taken, got.new_flag,
                        got.channels_seen));
                end else begin
                    want = replies_due.pop_front();
                    if (got.pulse_value !== want.pulse_value
                            || got.override_taken !== want.override_taken
                            || got.new_flag !== want.new_flag
                            || got.channels_seen !== want.channels_seen)
                        log_fault($sformatf({"item %0d: expected pulse %0d taken %0b ",
                            "flag %0b seen %0d, got pulse %0d taken %0b flag %0b seen %0d"},
                            replies_seen, want.pulse_value, want.override_taken,
                            want.new_flag, want.channels_seen, got.pulse_value,
                            got.override_taken, got.new_flag, got.channels_seen));
                end
                replies_seen++;
            end
            if (s_valid && s_ready)
                replies_due.push_back(decode_item(s_req_type, s_capture_time,
                                                  s_channel_index, s_override_value));
        end
        mismatch_count <= faults;
        replies_pending <= replies_due.size();
    end

endmodule

### sim/tb_ppm_rc_channel_decoder_top.sv
// tb_ppm_rc_channel_decoder_top: stimulus and verdict for the ppm rc decoder
// depends on ppmrc_pkg, ppm_rc_channel_decoder_top and ppmrc_reply_checker
module tb_ppm_rc_channel_decoder_top;
    import ppmrc_pkg::*;

    localparam int NCH            = 8;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int STALL_LIMIT    = 5000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0]   cfg_addr = '0;
    logic [15:0]          cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type = '0;
    logic [TIME_W-1:0]    s_capture_time = '0;
    logic [CH_W-1:0]      s_channel_index = '0;
    logic signed [15:0]   s_override_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PULSE_W-1:0]   m_pulse_value;
    logic                 m_override_taken;
    logic                 m_new_flag;
    logic [SEEN_W-1:0]    m_channels_seen;

    int mismatch_count;
    int replies_pending;

    // shared between sender and receiver
    bit steady = 1'b0;       // no idling on either side
    bit squeeze_req = 1'b0;  // receiver holds off for a long stretch

    // sender's view of the timer and the frame being built
    int stamp = 0;
    int cur_top = 40000;
    int cur_sync = 4600;
    int chans_left = 0;
    int quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ppm_rc_channel_decoder_top #(
        .CHAN_COUNT(NCH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_capture_time(s_capture_time),
        .s_channel_index(s_channel_index),
        .s_override_value(s_override_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pulse_value(m_pulse_value),
        .m_override_taken(m_override_taken),
        .m_new_flag(m_new_flag),
        .m_channels_seen(m_channels_seen)
    );

    ppmrc_reply_checker #(
        .CHAN_COUNT(NCH)
    ) u_reply_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_capture_time(s_capture_time),
        .s_channel_index(s_channel_index),
        .s_override_value(s_override_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pulse_value(m_pulse_value),
        .m_override_taken(m_override_taken),
        .m_new_flag(m_new_flag),
        .m_channels_seen(m_channels_seen),
        .mismatch_count(mismatch_count),
        .replies_pending(replies_pending)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 2) != 0)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 90);
        return $urandom_range(1, 4);
    endfunction

    // gap for a channel pulse, kept at or below the sync threshold
    function automatic int channel_gap();
        int hi;
        hi = (cur_sync < 5000) ? cur_sync : 5000;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, cur_sync);
        if (hi >= 1000)
            return $urandom_range(1000, hi);
        return $urandom_range(0, hi);
    endfunction

    // gap that closes a frame; none exists with the threshold at its top
    function automatic int sync_gap();
        int hi;
        if (cur_sync >= 65535)
            return 65535;
        hi = (cur_sync + 12000 > 65535) ? 65535 : cur_sync + 12000;
        return $urandom_range(cur_sync + 1, hi);
    endfunction

    // moves the sender's timer on by one gap, wrapping at the programmed top
    function automatic logic [TIME_W-1:0] advance_timer(input int gap);
        stamp = (stamp + gap) % cur_top;
        return TIME_W'(stamp);
    endfunction

    // offers one item and returns at the edge where it is accepted
    task automatic push_item(input logic [REQ_W-1:0]  req,
                             input logic [TIME_W-1:0] t,
                             input logic [CH_W-1:0]   ch,
                             input logic [15:0]       ov);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_capture_time <= t;
        s_channel_index <= ch;
        s_override_value <= ov;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait until every reply item has been taken
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (replies_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // writes all five registers back to back, only while the block is idle
    task automatic program_regs(input int top_v, input int sync_v, input int minch_v,
                                input int minp_v, input int maxp_v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_TIMER_TOP;
        cfg_wdata <= 16'(top_v);
        @(posedge aclk);
        cfg_addr <= CFG_SYNC_THRESH;
        cfg_wdata <= 16'(sync_v);
        @(posedge aclk);
        cfg_addr <= CFG_MIN_CHANNELS;
        cfg_wdata <= 16'(minch_v);
        @(posedge aclk);
        cfg_addr <= CFG_MIN_PULSE;
        cfg_wdata <= 16'(minp_v);
        @(posedge aclk);
        cfg_addr <= CFG_MAX_PULSE;
        cfg_wdata <= 16'(maxp_v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_top = top_v;
        cur_sync = sync_v;
        stamp = stamp % cur_top;
    endtask

    // directed corner items at the reset settings
    task automatic directed_items();
        push_item(REQ_TAKE_FLAG, 16'hFFFF, 8'hFF, 16'hFFFF);  // flag still clear
        push_item(REQ_READ, 16'h0000, 8'd0, 16'h0000);        // empty width, low clamp
        push_item(REQ_READ, 16'h0000, 8'd255, 16'h0000);      // channel out of range
        // sync first, then a full frame, one dropped pulse and a wrapping sync
        push_item(REQ_CAPTURE, advance_timer(10000), 8'd0, 16'h0000);
        push_item(REQ_CAPTURE, advance_timer(1000), 8'd0, 16'h0000);
        push_item(REQ_CAPTURE, advance_timer(4600), 8'd0, 16'h0000);  // equal to threshold
        repeat (6) push_item(REQ_CAPTURE, advance_timer(3000), 8'd0, 16'h0000);
        push_item(REQ_CAPTURE, advance_timer(3000), 8'd0, 16'h0000);  // store full, dropped
        push_item(REQ_CAPTURE, advance_timer(4601), 8'd0, 16'h0000);  // timer wraps here
        push_item(REQ_READ, 16'h0000, 8'd1, 16'h0000);                // high clamp
        // overrides: taken, bad channel, negative, removal, largest value
        push_item(REQ_SET_OVR, 16'h0000, 8'd1, 16'd1500);
        push_item(REQ_SET_OVR, 16'h0000, CH_W'(NCH), 16'd1500);
        push_item(REQ_SET_OVR, 16'h0000, 8'd2, 16'hFFFF);
        push_item(REQ_SET_OVR, 16'h0000, 8'd3, 16'h0000);
        push_item(REQ_SET_OVR, 16'h0000, 8'd0, 16'h7FFF);
        push_item(REQ_READ, 16'h0000, 8'd1, 16'h0000);
        push_item(REQ_READ, 16'h0000, 8'd0, 16'h0000);
        push_item(REQ_TAKE_FLAG, 16'h0000, 8'd0, 16'h0000);
        push_item(REQ_TAKE_FLAG, 16'h0000, 8'd0, 16'h0000);
        push_item(REQ_CLR_OVR, 16'h0000, 8'd0, 16'h0000);
        push_item(REQ_READ, 16'h0000, 8'd1, 16'h0000);
        push_item(3'd7, 16'hFFFF, 8'hFF, 16'hFFFF);                   // unknown request
    endtask

    // mostly well-formed frames with reads and overrides mixed in, some noise
    task automatic random_items(input int n);
        int pick;
        int g;
        logic [15:0] r16a;
        logic [15:0] r16b;
        logic [7:0]  r8;
        logic [7:0]  ch;
        logic [15:0] ov;
        for (int k = 0; k < n; k++) begin
            r16a = 16'($urandom);
            r16b = 16'($urandom);
            r8 = 8'($urandom);
            if (k % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            ch = ($urandom_range(0, 7) == 0) ? r8 : 8'($urandom_range(0, NCH - 1));
            pick = $urandom_range(0, 99);
            if (pick < 52) begin
                if (chans_left > 0) begin
                    g = channel_gap();
                    chans_left--;
                end else begin
                    g = sync_gap();
                    chans_left = $urandom_range(0, 10);
                end
                push_item(REQ_CAPTURE, advance_timer(g), r8, r16b);
            end else if (pick < 56) begin
                // right at or just past the threshold
                push_item(REQ_CAPTURE, advance_timer(cur_sync + $urandom_range(0, 1)),
                          r8, r16b);
            end else if (pick < 62) begin
                // stray edge anywhere on the timer
                push_item(REQ_CAPTURE, r16a, r8, r16b);
                stamp = r16a % cur_top;
            end else if (pick < 77) begin
                push_item(REQ_READ, r16a, ch, r16b);
            end else if (pick < 86) begin
                case ($urandom_range(0, 5))
                    0:       ov = r16b | 16'h8000;
                    1:       ov = 16'h0000;
                    2:       ov = 16'h7FFF;
                    3:       ov = r16b;
                    default: ov = 16'($urandom_range(800, 2200));
                endcase
                push_item(REQ_SET_OVR, r16a, ch, ov);
            end else if (pick < 93) begin
                push_item(REQ_TAKE_FLAG, r16a, r8, r16b);
            end else if (pick < 96) begin
                push_item(REQ_CLR_OVR, r16a, r8, r16b);
            end else begin
                push_item(3'($urandom_range(5, 7)), r16a, r8, r16b);
            end
        end
    endtask

    // receiver: random ready pattern, a long hold-off when asked
    initial begin : receiver
        int idle;
        @(posedge aclk);
        forever begin
            if (squeeze_req) begin
                m_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge aclk);
                squeeze_req = 1'b0;
            end else begin
                idle = steady ? 0 : pick_gap();
                if (idle > 0) begin
                    m_ready <= 1'b0;
                    repeat (idle) @(posedge aclk);
                end else begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 6)) @(posedge aclk);
                end
            end
        end
    end

    // watchdog: too long without any item moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // sender: reset, directed items, then phases of random items per setting
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_items();
        random_items(250);

        // widest timer, publish at any count, no clamping
        settle();
        program_regs(65535, 4600, 0, 0, 65535);
        random_items(250);

        // every nonzero gap is a sync, full frames only, crossed clamp limits
        settle();
        program_regs(40000, 0, 8, 2100, 900);
        random_items(250);

        // timer stuck at zero, sync never seen
        settle();
        program_regs(1, 65535, 3, 1000, 2000);
        random_items(150);

        // random settings; the receiver holds off while items keep coming
        settle();
        program_regs($urandom_range(1000, 65535), $urandom_range(2000, 8000),
                     $urandom_range(0, 8), $urandom_range(0, 1500),
                     $urandom_range(1500, 3000));
        squeeze_req = 1'b1;
        random_items(40);
        while (squeeze_req) @(posedge aclk);
        random_items(250);

        settle();
        program_regs(40000, 6000, 4, 1000, 2000);
        random_items(300);

        // back to the reset values
        settle();
        program_regs(40000, 4600, 5, 900, 2100);
        random_items(350);

        settle();
        if (mismatch_count == 0 && replies_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
